// File: rtl/core/sukt_pkg.sv
// ----------------------------------------------------------------------------
// sukt_pkg
// Types and constants shared by the sorted unique key table.
// ----------------------------------------------------------------------------
package sukt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CODE_W   = 31;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 3;

    // op codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO   = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADIDX = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [ADDR_W-1:0] read_index;
    } sukt_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] position;
        logic [CODE_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } sukt_rsp_t;

    // read address source
    typedef enum logic [2:0] {
        RD_IDX    = 3'd0,
        RD_IDX_P1 = 3'd1,
        RD_IDX_M2 = 3'd2,
        RD_IDX_P2 = 3'd3,
        RD_RIDX   = 3'd4,
        RD_CNT_M1 = 3'd5
    } rd_sel_t;

    // position register source
    typedef enum logic [1:0] {
        POS_HOLD = 2'd0,
        POS_IDX  = 2'd1,
        POS_CNT  = 2'd2,
        POS_RIDX = 2'd3
    } pos_sel_t;

    typedef struct packed {
        logic              cap_req;
        logic              idx_clr;
        logic              idx_inc;
        logic              idx_dec;
        logic              idx_from_cnt;
        pos_sel_t          pos_sel;
        rd_sel_t           rd_sel;
        logic              wr_shift;
        logic              wr_code;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              rsp_load;
        logic [STAT_W-1:0] rsp_status;
    } sukt_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            code_zero;
        logic            cnt_zero;
        logic            cnt_full;
        logic            ridx_bad;
        logic            key_ge;
        logic            key_eq;
        logic            scan_last;
        logic            up_last;
        logic            dn_last;
    } sukt_sts_t;

endpackage

// File: rtl/core/sukt_ram.sv
// ----------------------------------------------------------------------------
// sukt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sukt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sukt_ctrl.sv
// ----------------------------------------------------------------------------
// sukt_ctrl
// Sequencer: scan for the sorted position, shift entries, build the result.
// ----------------------------------------------------------------------------
module sukt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sukt_pkg::sukt_sts_t sts,
    output sukt_pkg::sukt_cmd_t cmd
);
    import sukt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_SH_UP    = 7'b0001000,
        S_SH_DN    = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_RD_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.pos_sel    = POS_HOLD;
        cmd.rd_sel     = RD_IDX;
        cmd.rsp_status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.cap_req = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                if (sts.op == OP_INSERT || sts.op == OP_REMOVE)
                begin
                    if (sts.code_zero)
                    begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_ZERO;
                        state_next     = S_IDLE;
                    end
                    else if (sts.cnt_zero)
                    begin
                        if (sts.op == OP_INSERT)
                        begin
                            cmd.pos_sel = POS_CNT;
                            state_next  = S_PUT;
                        end
                        else
                        begin
                            cmd.rsp_load   = 1'b1;
                            cmd.rsp_status = ST_ABSENT;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        // index is zero here: fetch the first entry
                        cmd.rd_sel = RD_IDX;
                        state_next = S_SCAN;
                    end
                end
                else if (sts.op == OP_READ && !sts.ridx_bad)
                begin
                    cmd.rd_sel  = RD_RIDX;
                    cmd.pos_sel = POS_RIDX;
                    state_next  = S_RD_WAIT;
                end
                else
                begin
                    cmd.rsp_load   = 1'b1;
                    cmd.rsp_status = ST_BADIDX;
                    state_next     = S_IDLE;
                end
            end

            S_SCAN:
            begin
                cmd.rd_sel = RD_IDX_P1;
                if (sts.key_ge && sts.key_eq && sts.op == OP_INSERT)
                begin
                    cmd.rsp_load   = 1'b1;
                    cmd.rsp_status = ST_DUP;
                    state_next     = S_IDLE;
                end
                else if (sts.key_ge && sts.key_eq)
                begin
                    // remove hit at idx
                    cmd.pos_sel = POS_IDX;
                    if (sts.scan_last)
                    begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.rsp_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SH_DN;
                    end
                end
                else if ((sts.key_ge || sts.scan_last) && sts.op == OP_REMOVE)
                begin
                    cmd.rsp_load   = 1'b1;
                    cmd.rsp_status = ST_ABSENT;
                    state_next     = S_IDLE;
                end
                else if (sts.key_ge || sts.scan_last)
                begin
                    if (sts.cnt_full)
                    begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else if (sts.key_ge)
                    begin
                        cmd.pos_sel      = POS_IDX;
                        cmd.idx_from_cnt = 1'b1;
                        cmd.rd_sel       = RD_CNT_M1;
                        state_next       = S_SH_UP;
                    end
                    else
                    begin
                        // larger than every entry: append
                        cmd.pos_sel = POS_CNT;
                        state_next  = S_PUT;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end

            S_SH_UP:
            begin
                cmd.wr_shift = 1'b1;
                cmd.rd_sel   = RD_IDX_M2;
                cmd.idx_dec  = 1'b1;
                if (sts.up_last)
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                cmd.wr_code  = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.rsp_load = 1'b1;
                state_next   = S_IDLE;
            end

            S_SH_DN:
            begin
                cmd.wr_shift = 1'b1;
                cmd.rd_sel   = RD_IDX_P2;
                cmd.idx_inc  = 1'b1;
                if (sts.dn_last)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_RD_WAIT:
            begin
                cmd.rsp_load = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/sukt_dp.sv
// ----------------------------------------------------------------------------
// sukt_dp
// Datapath: request and count registers, scan pointer, key RAM, result beat.
// ----------------------------------------------------------------------------
module sukt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sukt_pkg::sukt_req_t req,
    input  sukt_pkg::sukt_cmd_t cmd,
    output sukt_pkg::sukt_sts_t sts,
    output logic                done,
    output sukt_pkg::sukt_rsp_t rsp
);
    import sukt_pkg::*;

    sukt_req_t         req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic              done_reg;
    sukt_rsp_t         rsp_reg;
    sukt_rsp_t         rsp_next;

    logic [ADDR_W-1:0] rd_addr;
    logic [CODE_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CODE_W-1:0] wr_data;
    logic [CNT_W-1:0]  idx_wide;

    sukt_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_wide = {{(CNT_W-ADDR_W){1'b0}}, idx_reg};

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = idx_reg;
            RD_IDX_P1: rd_addr = idx_reg + ADDR_W'(1);
            RD_IDX_M2: rd_addr = idx_reg - ADDR_W'(2);
            RD_IDX_P2: rd_addr = idx_reg + ADDR_W'(2);
            RD_RIDX:   rd_addr = req_reg.read_index;
            RD_CNT_M1: rd_addr = count_reg[ADDR_W-1:0] - ADDR_W'(1);
            default:   rd_addr = idx_reg;
        endcase
    end

    assign wr_en   = cmd.wr_shift | cmd.wr_code;
    assign wr_addr = cmd.wr_code ? pos_reg : idx_reg;
    assign wr_data = cmd.wr_code ? req_reg.code : rd_data;

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_from_cnt)
        begin
            idx_next = count_reg[ADDR_W-1:0];
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - ADDR_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        case (cmd.pos_sel)
            POS_HOLD: pos_next = pos_reg;
            POS_IDX:  pos_next = idx_reg;
            POS_CNT:  pos_next = count_reg[ADDR_W-1:0];
            POS_RIDX: pos_next = req_reg.read_index;
            default:  pos_next = pos_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        rsp_next.status   = cmd.rsp_status;
        rsp_next.position = (cmd.rsp_status == ST_OK) ? pos_next : '0;
        rsp_next.value    = (cmd.rsp_status == ST_OK && req_reg.op == OP_READ) ?
                            rd_data : '0;
        rsp_next.count    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.rsp_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_reg <= req;
        end
        if (cmd.rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
        idx_reg <= idx_next;
        pos_reg <= pos_next;
    end

    // status toward the sequencer
    assign sts.op        = req_reg.op;
    assign sts.code_zero = (req_reg.code == '0);
    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.cnt_full  = (count_reg == CNT_W'(CAPACITY));
    assign sts.ridx_bad  = ({{(CNT_W-ADDR_W){1'b0}}, req_reg.read_index} >= count_reg);
    assign sts.key_ge    = (rd_data >= req_reg.code);
    assign sts.key_eq    = (rd_data == req_reg.code);
    assign sts.scan_last = ((idx_wide + CNT_W'(1)) == count_reg);
    assign sts.up_last   = (idx_reg == (pos_reg + ADDR_W'(1)));
    assign sts.dn_last   = ((idx_wide + CNT_W'(2)) == count_reg);

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/core/sorted_unique_key_table_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table_core
// Sorted table of unique nonzero codes with insert, remove and indexed read.
// ----------------------------------------------------------------------------
// Insert and remove scan the table for the sorted position, then shift
//   entries through the one-read one-write key RAM; read looks up one entry.
// Throughput: one op at a time; a new start is taken in the cycle done pulses.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset clears the entry count; RAM contents are left as they are.
// ----------------------------------------------------------------------------
module sorted_unique_key_table_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sukt_pkg::sukt_req_t req,
    output logic                done,
    output sukt_pkg::sukt_rsp_t rsp
);
    import sukt_pkg::*;

    sukt_cmd_t cmd;
    sukt_sts_t sts;

    sukt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    sukt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for sorted_unique_key_table_core. A shadow copy of the sorted
// table predicts status, position, value and count for each accepted beat.
// Directed tests cover the empty and full table. Random tests then sweep the
// fill level up and down with mostly legal inserts, removes and reads.
// ----------------------------------------------------------------------------
module tb;
    import sukt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    sukt_req_t req;
    logic      done;
    sukt_rsp_t rsp;

    logic [CODE_W-1:0] sorted_codes[$];
    sukt_rsp_t         pending_results[$];
    int                failures = 0;
    int                quiet_cycles = 0;
    bit                burst_mode = 1'b0;

    sorted_unique_key_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int find_code(input logic [CODE_W-1:0] c);
        foreach (sorted_codes[i])
        begin
            if (sorted_codes[i] == c)
                return i;
        end
        return -1;
    endfunction

    // shadow table update; returns what the block should answer
    function automatic sukt_rsp_t apply_table_op(input sukt_req_t item);
        sukt_rsp_t res;
        int        hit;
        int        slot;
        res = '0;
        hit = find_code(item.code);
        case (item.op)
            OP_INSERT:
            begin
                if (item.code == '0)
                    res.status = ST_ZERO;
                else if (hit >= 0)
                    res.status = ST_DUP;
                else if (sorted_codes.size() >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    slot = sorted_codes.size();
                    for (int i = sorted_codes.size() - 1; i >= 0; i--)
                    begin
                        if (sorted_codes[i] > item.code)
                            slot = i;
                    end
                    sorted_codes.insert(slot, item.code);
                    res.status   = ST_OK;
                    res.position = ADDR_W'(slot);
                end
            end
            OP_REMOVE:
            begin
                if (item.code == '0)
                    res.status = ST_ZERO;
                else if (hit < 0)
                    res.status = ST_ABSENT;
                else
                begin
                    sorted_codes.delete(hit);
                    res.status   = ST_OK;
                    res.position = ADDR_W'(hit);
                end
            end
            OP_READ:
            begin
                if (item.read_index >= sorted_codes.size())
                    res.status = ST_BADIDX;
                else
                begin
                    res.status   = ST_OK;
                    res.position = item.read_index;
                    res.value    = sorted_codes[item.read_index];
                end
            end
            default:
                res.status = ST_BADIDX;
        endcase
        res.count = CNT_W'(sorted_codes.size());
        return res;
    endfunction

    function automatic sukt_req_t make_req(input logic [OP_W-1:0] op,
                                           input logic [CODE_W-1:0] c,
                                           input int idx);
        sukt_req_t r;
        r.op         = op;
        r.code       = c;
        r.read_index = ADDR_W'(idx);
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return CODE_W'($urandom_range(1, 100));
        if (roll < 30)
            return CODE_W'(1);
        if (roll < 35)
            return CODE_MAX;
        return CODE_W'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] fresh_code();
        logic [CODE_W-1:0] c;
        do
            c = rand_code();
        while (c == '0 || find_code(c) >= 0);
        return c;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high from one beat to the next when there is no gap
    task automatic send_op(input sukt_req_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(apply_table_op(item));
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        failures++;
        if (failures <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h",
                     $realtime, what, exp_val, act_val);
    endtask

    always @(posedge clk)
    begin
        sukt_rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected result", 32'd0, 32'd1);
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch("status", want.status, rsp.status);
                if (rsp.position !== want.position)
                    note_mismatch("position", want.position, rsp.position);
                if (rsp.value !== want.value)
                    note_mismatch("value", want.value, rsp.value);
                if (rsp.count !== want.count)
                    note_mismatch("count", want.count, rsp.count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_empty_table();
        send_op(make_req(OP_READ, '0, 0));
        send_op(make_req(OP_READ, CODE_MAX, 63));
        send_op(make_req(OP_REMOVE, CODE_W'(12345), 0));
        send_op(make_req(OP_REMOVE, '0, 63));
        send_op(make_req(OP_INSERT, '0, 0));
        send_op(make_req(OP_UNUSED, CODE_MAX, 63));
    endtask

    task automatic test_basic_ops();
        send_op(make_req(OP_INSERT, CODE_MAX, 0));
        send_op(make_req(OP_INSERT, CODE_W'(1), 63));
        send_op(make_req(OP_INSERT, CODE_W'(31'h4000_0000), 0));
        send_op(make_req(OP_INSERT, CODE_W'(31'h2aaa_aaaa), 0));
        send_op(make_req(OP_INSERT, CODE_W'(31'h5555_5555), 0));
        send_op(make_req(OP_INSERT, CODE_W'(1), 0));
        send_op(make_req(OP_INSERT, CODE_MAX, 0));
        for (int i = 0; i <= 5; i++)
            send_op(make_req(OP_READ, CODE_MAX, i));
        send_op(make_req(OP_REMOVE, CODE_W'(31'h4000_0000), 0));
        send_op(make_req(OP_REMOVE, CODE_W'(31'h4000_0000), 0));
        send_op(make_req(OP_REMOVE, CODE_MAX, 0));
        send_op(make_req(OP_REMOVE, CODE_W'(1), 0));
        send_op(make_req(OP_REMOVE, '0, 0));
        send_op(make_req(OP_UNUSED, CODE_W'($urandom), $urandom_range(0, 63)));
    endtask

    // zero beats duplicate beats full on a full table
    task automatic test_full_table();
        logic [CODE_W-1:0] top;
        while (sorted_codes.size() < CAPACITY)
            send_op(make_req(OP_INSERT, fresh_code(), $urandom_range(0, 63)));
        send_op(make_req(OP_INSERT, fresh_code(), 0));
        send_op(make_req(OP_INSERT, sorted_codes[0], 0));
        send_op(make_req(OP_INSERT, '0, 0));
        send_op(make_req(OP_READ, '0, 63));
        send_op(make_req(OP_READ, '0, 0));
        top = sorted_codes[CAPACITY-1];
        send_op(make_req(OP_REMOVE, top, 0));
        send_op(make_req(OP_READ, '0, 63));
        send_op(make_req(OP_INSERT, top, 0));
    endtask

    task automatic test_random(input int n_items);
        sukt_req_t item;
        int        target;
        int        roll;
        int        n;
        bit        grow;
        target = CAPACITY;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 150 == 0)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 2)
                    target = CAPACITY;
                else if (roll < 4)
                    target = $urandom_range(0, 4);
                else
                    target = $urandom_range(0, CAPACITY);
                burst_mode = ($urandom_range(0, 4) == 0);
            end
            n = sorted_codes.size();
            roll = $urandom_range(0, 99);
            if (roll < 20 && n > 0)
                item = make_req(OP_READ, CODE_W'($urandom), $urandom_range(0, n - 1));
            else if (roll < 80)
            begin
                grow = (n == 0) || (n < target) ||
                       (n == target && $urandom_range(0, 1) == 1);
                if (grow)
                    item = make_req(OP_INSERT, fresh_code(), $urandom_range(0, 63));
                else
                    item = make_req(OP_REMOVE, sorted_codes[$urandom_range(0, n - 1)],
                                    $urandom_range(0, 63));
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:
                        item = make_req(OP_INSERT,
                                        (n > 0) ? sorted_codes[$urandom_range(0, n - 1)] : '0,
                                        $urandom_range(0, 63));
                    1:
                    begin
                        item = make_req(OP_REMOVE, rand_code(), $urandom_range(0, 63));
                        while (item.code == '0 || find_code(item.code) >= 0)
                            item.code = rand_code();
                    end
                    2:
                        item = make_req($urandom_range(0, 1) ? OP_INSERT : OP_REMOVE,
                                        '0, $urandom_range(0, 63));
                    3:
                        item = make_req(OP_READ, CODE_W'($urandom), $urandom_range(0, 63));
                    4:
                        item = make_req(OP_UNUSED, CODE_W'($urandom), $urandom_range(0, 63));
                    default:
                        item = make_req(OP_W'($urandom_range(0, 3)), rand_code(),
                                        $urandom_range(0, 63));
                endcase
            end
            send_op(item);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_random(1400);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sukt_pkg.sv
rtl/core/sukt_ram.sv
rtl/core/sukt_ctrl.sv
rtl/core/sukt_dp.sv
rtl/core/sorted_unique_key_table_core.sv
test/tb.sv
